// ----- sv/pval_pkg.sv -----
// ----------------------------------------------------------------------------
// pval_pkg: shared types, constants and GF(2^128) helpers
// Digit sizes, register indexes, the controller command bundle and the
// carry-less multiply and reduction functions used by the POLYVAL datapath.
// ----------------------------------------------------------------------------
package pval_pkg;

  localparam int unsigned HALF_W     = 64;
  localparam int unsigned BLOCK_W    = 2 * HALF_W;
  localparam int unsigned PROD_W     = 2 * BLOCK_W;
  localparam int unsigned DIGIT_W    = 16;
  localparam int unsigned NUM_DIGITS = BLOCK_W / DIGIT_W;
  localparam int unsigned CNT_W      = $clog2(NUM_DIGITS);
  localparam int unsigned CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture block and key, clear partial product
    logic step;    // absorb one key digit, MSB first
    logic finish;  // reduce, update accumulator and digest register
  } pval_cmd_t;

  // Carry-less 128 x 16 multiply
  function automatic logic [BLOCK_W+DIGIT_W-1:0] clmul_digit(
      input logic [BLOCK_W-1:0] a, input logic [DIGIT_W-1:0] d);
    logic [BLOCK_W+DIGIT_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < DIGIT_W; i++) begin
      if (d[i]) acc = acc ^ ({{DIGIT_W{1'b0}}, a} << i);
    end
    return acc;
  endfunction

  // One folding pass with the reflected constant 0xc2 << 56 (bits 63, 62, 57)
  function automatic logic [BLOCK_W-1:0] fold(input logic [BLOCK_W-1:0] v);
    logic [BLOCK_W-1:0] ext;
    logic [BLOCK_W-1:0] t;
    ext = {{HALF_W{1'b0}}, v[HALF_W-1:0]};
    t   = (ext << 63) ^ (ext << 62) ^ (ext << 57);
    return {t[BLOCK_W-1:HALF_W] ^ v[HALF_W-1:0], t[HALF_W-1:0] ^ v[BLOCK_W-1:HALF_W]};
  endfunction

  // Montgomery-style reduction of the 256-bit product: p * x^-128 mod poly
  function automatic logic [BLOCK_W-1:0] reduce(input logic [PROD_W-1:0] p);
    logic [BLOCK_W-1:0] lo;
    lo = fold(fold(p[BLOCK_W-1:0]));
    return p[PROD_W-1:BLOCK_W] ^ lo;
  endfunction

endpackage

// ----- sv/pval_ctrl.sv -----
// ----------------------------------------------------------------------------
// pval_ctrl: sequencing for the POLYVAL accumulator
// Accepts one block, runs the digit-serial multiply, then the reduction,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module pval_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                out_stall,
  output logic                out_valid,
  output pval_pkg::pval_cmd_t cmd
);
  import pval_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_RED
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;

  // Commands decoded from state
  always_comb begin
    cmd        = '0;
    cmd.load   = (state == ST_IDLE) && in_valid;
    cmd.step   = (state == ST_MUL);
    cmd.finish = (state == ST_RED) && (!out_valid || !out_stall);
  end

  assign in_stall = (state != ST_IDLE);

  // Hold state, digit count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop the result once taken; a new one replaces it on finish
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (cmd.load) begin
            state <= ST_MUL;
            cnt   <= '0;
          end
        end
        ST_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(NUM_DIGITS - 1)) state <= ST_RED;
        end
        ST_RED: begin
          if (cmd.finish) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/pval_datapath.sv -----
// ----------------------------------------------------------------------------
// pval_datapath: key registers, accumulator and digit-serial GF multiplier
// Horner-style 128 x 16 carry-less steps build the 256-bit product, which
// is folded twice with the POLYVAL constant into the new accumulator.
// ----------------------------------------------------------------------------
module pval_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [pval_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pval_pkg::HALF_W-1:0]        cfg_data,
  input  pval_pkg::pval_cmd_t                cmd,
  input  logic [pval_pkg::HALF_W-1:0]        block_low,
  input  logic [pval_pkg::HALF_W-1:0]        block_high,
  input  logic                               start_new,
  input  logic                               last_block,
  output logic [pval_pkg::HALF_W-1:0]        digest_low,
  output logic [pval_pkg::HALF_W-1:0]        digest_high,
  output logic                               digest_final
);
  import pval_pkg::*;

  logic [HALF_W-1:0]  key_low;
  logic [HALF_W-1:0]  key_high;
  logic [BLOCK_W-1:0] acc;
  logic [BLOCK_W-1:0] opa;
  logic [BLOCK_W-1:0] kshift;
  logic [PROD_W-1:0]  prod;
  logic               last;
  logic [BLOCK_W-1:0] acc_next;
  logic [BLOCK_W-1:0] opa_next;

  assign opa_next = (start_new ? '0 : acc) ^ {block_high, block_low};
  assign acc_next = reduce(prod);

  // Key registers and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
      acc      <= '0;
    end else begin
      if (cfg_write && cfg_index == REG_KEY_LOW)  key_low  <= cfg_data;
      if (cfg_write && cfg_index == REG_KEY_HIGH) key_high <= cfg_data;
      if (cmd.finish) acc <= acc_next;
    end
  end

  // Multiplier operands, partial product and digest register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opa    <= opa_next;
      kshift <= {key_high, key_low};
      prod   <= '0;
      last   <= last_block;
    end
    if (cmd.step) begin
      prod   <= (prod << DIGIT_W) ^
                {{(PROD_W-BLOCK_W-DIGIT_W){1'b0}},
                 clmul_digit(opa, kshift[BLOCK_W-1 -: DIGIT_W])};
      kshift <= kshift << DIGIT_W;
    end
    if (cmd.finish) begin
      digest_low   <= acc_next[HALF_W-1:0];
      digest_high  <= acc_next[BLOCK_W-1:HALF_W];
      digest_final <= last;
    end
  end

endmodule

// ----- sv/polyval_accumulator_core.sv -----
// ----------------------------------------------------------------------------
// polyval_accumulator_core: POLYVAL GF(2^128) hash accumulator
// XORs each 128-bit block into the accumulator (or zero, on start_new) and
// multiplies by the key.
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   in      | input     | in_valid/in_stall  | block_low, block_high, start_new,
//           |           |                    | last_block
//   out     | output    | out_valid/out_stall| digest_low, digest_high,
//           |           |                    | digest_final
//   cfg     | input     | cfg_write          | cfg_index, cfg_data
//
// A block passes through an accept step, eight 16-bit digit steps of the
// carry-less multiplier and one fold step, which registers the digest.
// The next block is accepted the cycle after the digest is registered, even
// while that digest is still stalled; the fold cycle waits if an older digest
// has not been taken. Reset clears key, accumulator and result valid flag.
// ----------------------------------------------------------------------------
module polyval_accumulator_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [pval_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pval_pkg::HALF_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pval_pkg::HALF_W-1:0]    block_low,
  input  logic [pval_pkg::HALF_W-1:0]    block_high,
  input  logic                           start_new,
  input  logic                           last_block,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pval_pkg::HALF_W-1:0]    digest_low,
  output logic [pval_pkg::HALF_W-1:0]    digest_high,
  output logic                           digest_final
);
  import pval_pkg::*;

  pval_cmd_t cmd;

  pval_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  pval_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .block_low    (block_low),
    .block_high   (block_high),
    .start_new    (start_new),
    .last_block   (last_block),
    .digest_low   (digest_low),
    .digest_high  (digest_high),
    .digest_final (digest_final)
  );

  // An accepted transaction keeps the input side busy while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted again right after a transaction");

  // A fresh digest only ever comes from a finish command
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("result valid rose without a finish");

  // Commands never overlap
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.step, cmd.finish}))
    else $error("overlapping datapath commands");

endmodule
